### hdl/eight_bit_cpu_subset_core_assert.svh
// Assertion macros for the core checker.
`ifndef EIGHT_BIT_CPU_SUBSET_CORE_ASSERT_SVH
`define EIGHT_BIT_CPU_SUBSET_CORE_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define ECS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ECS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

### hdl/ecs_pkg.sv
// ----------------------------------------------------------------------------
// ecs_pkg
// Shared constants and types of the 8080 subset core.
// ----------------------------------------------------------------------------
package ecs_pkg;
    localparam int ADDR_BITS = 16;
    localparam int MEM_DEPTH = 1 << ADDR_BITS;

    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_EXEC  = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_UNIMPL = 2'd1;
    localparam logic [1:0] ST_HALTED = 2'd2;

    localparam logic [7:0] OP_NOP   = 8'h00;
    localparam logic [7:0] OP_DCRB  = 8'h05;
    localparam logic [7:0] OP_MVIB  = 8'h06;
    localparam logic [7:0] OP_MVIC  = 8'h0e;
    localparam logic [7:0] OP_LXID  = 8'h11;
    localparam logic [7:0] OP_INXD  = 8'h13;
    localparam logic [7:0] OP_LDAXD = 8'h1a;
    localparam logic [7:0] OP_LXIH  = 8'h21;
    localparam logic [7:0] OP_INXH  = 8'h23;
    localparam logic [7:0] OP_MVIH  = 8'h26;
    localparam logic [7:0] OP_DADH  = 8'h29;
    localparam logic [7:0] OP_LXISP = 8'h31;
    localparam logic [7:0] OP_MVIM  = 8'h36;
    localparam logic [7:0] OP_MOVLA = 8'h6f;
    localparam logic [7:0] OP_MOVMA = 8'h77;
    localparam logic [7:0] OP_MOVAH = 8'h7c;
    localparam logic [7:0] OP_JNZ   = 8'hc2;
    localparam logic [7:0] OP_JMP   = 8'hc3;
    localparam logic [7:0] OP_RET   = 8'hc9;
    localparam logic [7:0] OP_CALL  = 8'hcd;
    localparam logic [7:0] OP_PUSHD = 8'hd5;
    localparam logic [7:0] OP_PUSHH = 8'he5;
    localparam logic [7:0] OP_CPI   = 8'hfe;

    typedef enum logic [1:0] {
        ALU_ADD16 = 2'd0,
        ALU_SUB8  = 2'd1,
        ALU_DEC8  = 2'd2
    } t_alu_op;

    typedef struct packed {
        t_alu_op     op;
        logic [15:0] a;
        logic [15:0] b;
    } t_alu_req;

    typedef struct packed {
        logic [15:0] res;
        logic        cy;
        logic [3:0]  zsp;
    } t_alu_rsp;
endpackage

### hdl/ecs_ram.sv
// ----------------------------------------------------------------------------
// ecs_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module ecs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

### hdl/ecs_alu.sv
// ----------------------------------------------------------------------------
// ecs_alu
// Shared adder/subtractor with flag generation.
// ----------------------------------------------------------------------------
module ecs_alu (
    input  ecs_pkg::t_alu_req i_req,
    output ecs_pkg::t_alu_rsp o_rsp
);
    logic [16:0] sum;
    logic [7:0]  r8;

    always_comb begin
        sum = 17'd0;
        case (i_req.op)
            ecs_pkg::ALU_ADD16: sum = {1'b0, i_req.a} + {1'b0, i_req.b};
            ecs_pkg::ALU_SUB8:  sum = {9'd0, i_req.a[7:0]} - {9'd0, i_req.b[7:0]};
            ecs_pkg::ALU_DEC8:  sum = {9'd0, i_req.a[7:0]} - 17'd1;
            default:            sum = 17'd0;
        endcase
        r8 = sum[7:0];
        o_rsp.res = sum[15:0];
        o_rsp.cy  = (i_req.op == ecs_pkg::ALU_ADD16) ? sum[16] :
                    (i_req.a[7:0] < i_req.b[7:0]);
        o_rsp.zsp = {1'b0, ~^r8, r8[7], r8 == 8'd0};
    end
endmodule

### hdl/eight_bit_cpu_subset_core.sv
// ----------------------------------------------------------------------------
// eight_bit_cpu_subset_core
// 8080 instruction subset core with a private byte memory.
// ----------------------------------------------------------------------------
// A memory write, an ignored item or an execute while halted goes straight to
// the result state; a memory read and the shortest execute take longer, and
// CALL is the longest, as the single memory port (one access per cycle,
// registered read) walks opcode, operands and stack bytes.
// One item in flight: the next is taken only after the result is accepted.
// Synchronous active-low reset clears registers, flags, halt; memory is not.
module eight_bit_cpu_subset_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_opcode,
    input  logic [15:0] i_mem_address,
    input  logic [7:0]  i_mem_data,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic [15:0] o_prog_counter,
    output logic [7:0]  o_acc,
    output logic [7:0]  o_reg_b,
    output logic [7:0]  o_reg_c,
    output logic [7:0]  o_reg_d,
    output logic [7:0]  o_reg_e,
    output logic [7:0]  o_reg_h,
    output logic [7:0]  o_reg_l,
    output logic [15:0] o_stack_ptr,
    output logic [3:0]  o_flag_bits,
    output logic [7:0]  o_read_byte
);
    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_FETCH = 7'b0000010,
        S_OP    = 7'b0000100,
        S_RD1   = 7'b0001000,
        S_RD2   = 7'b0010000,
        S_WR    = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic [15:0] r_pc, n_pc, r_sp, n_sp;
    logic [7:0]  r_a, n_a, r_b, n_b, r_c, n_c, r_d, n_d, r_e, n_e, r_h, n_h, r_l, n_l;
    logic [3:0]  r_f, n_f;
    logic        r_halt, n_halt, r_valid, n_valid;
    logic [1:0]  r_cmd, n_cmd, r_status, n_status;
    logic [7:0]  r_op, n_op, r_lo, n_lo, r_rb, n_rb, r_wd2, n_wd2;
    logic [15:0] r_wa2, n_wa2;
    logic [1:0]  r_step, n_step;
    logic [15:0] r_addr, n_addr;
    logic [7:0]  r_wdat, n_wdat;
    logic        r_we, n_we;

    logic [7:0]  mem_q;
    ecs_pkg::t_alu_req alu_req;
    ecs_pkg::t_alu_rsp alu_rsp;

    ecs_ram #(.WIDTH(8), .DEPTH(ecs_pkg::MEM_DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (r_we),
        .i_addr  (r_addr[ecs_pkg::ADDR_BITS-1:0]),
        .i_wdata (r_wdat),
        .o_rdata (mem_q)
    );

    ecs_alu u_alu (.i_req(alu_req), .o_rsp(alu_rsp));

    always_comb begin
        alu_req.op = ecs_pkg::ALU_ADD16;
        alu_req.a  = {r_h, r_l};
        alu_req.b  = {r_h, r_l};
        case (r_op)
            ecs_pkg::OP_DCRB: begin
                alu_req.op = ecs_pkg::ALU_DEC8;
                alu_req.a  = {8'd0, r_b};
            end
            ecs_pkg::OP_CPI: begin
                alu_req.op = ecs_pkg::ALU_SUB8;
                alu_req.a  = {8'd0, r_a};
                alu_req.b  = {8'd0, mem_q};
            end
            default: ;
        endcase
    end

    always_comb begin
        n_state = r_state; n_pc = r_pc; n_sp = r_sp;
        n_a = r_a; n_b = r_b; n_c = r_c; n_d = r_d; n_e = r_e; n_h = r_h; n_l = r_l;
        n_f = r_f; n_halt = r_halt; n_valid = r_valid; n_cmd = r_cmd;
        n_status = r_status; n_op = r_op; n_lo = r_lo; n_rb = r_rb;
        n_wd2 = r_wd2; n_wa2 = r_wa2; n_step = r_step;
        n_addr = r_addr; n_wdat = r_wdat; n_we = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_cmd = i_opcode; n_status = ecs_pkg::ST_OK; n_rb = 8'd0;
                    n_addr = i_mem_address; n_wdat = i_mem_data;
                    n_state = S_DONE;
                    case (i_opcode)
                        ecs_pkg::CMD_WRITE: n_we = 1'b1;
                        ecs_pkg::CMD_READ:  n_state = S_FETCH;
                        ecs_pkg::CMD_EXEC: begin
                            if (r_halt) begin
                                n_status = ecs_pkg::ST_HALTED;
                            end else begin
                                n_addr = r_pc; n_state = S_FETCH;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_FETCH: begin
                if (r_cmd == ecs_pkg::CMD_READ) begin
                    n_state = S_OP;
                end else begin
                    n_state = S_OP;
                end
                n_addr = r_pc + 16'd1;
            end
            S_OP: begin
                if (r_cmd == ecs_pkg::CMD_READ) begin
                    n_rb = mem_q; n_state = S_DONE;
                end else begin
                    n_op = mem_q; n_state = S_DONE;
                    n_addr = r_pc + 16'd1;
                    case (mem_q)
                        ecs_pkg::OP_NOP: n_pc = r_pc + 16'd1;
                        ecs_pkg::OP_DCRB, ecs_pkg::OP_DADH, ecs_pkg::OP_MVIB,
                        ecs_pkg::OP_MVIC, ecs_pkg::OP_MVIH, ecs_pkg::OP_MVIM,
                        ecs_pkg::OP_CPI, ecs_pkg::OP_LXID, ecs_pkg::OP_LXIH,
                        ecs_pkg::OP_LXISP, ecs_pkg::OP_JNZ, ecs_pkg::OP_JMP,
                        ecs_pkg::OP_CALL: begin
                            n_state = S_RD1;
                        end
                        ecs_pkg::OP_INXD: begin
                            {n_d, n_e} = {r_d, r_e} + 16'd1; n_pc = r_pc + 16'd1;
                        end
                        ecs_pkg::OP_INXH: begin
                            {n_h, n_l} = {r_h, r_l} + 16'd1; n_pc = r_pc + 16'd1;
                        end
                        ecs_pkg::OP_LDAXD: begin
                            n_addr = {r_d, r_e}; n_state = S_RD1;
                        end
                        ecs_pkg::OP_RET: begin
                            n_addr = r_sp; n_state = S_RD1;
                        end
                        ecs_pkg::OP_MOVLA: begin
                            n_l = r_a; n_pc = r_pc + 16'd1;
                        end
                        ecs_pkg::OP_MOVAH: begin
                            n_a = r_h; n_pc = r_pc + 16'd1;
                        end
                        ecs_pkg::OP_MOVMA: begin
                            n_addr = {r_h, r_l}; n_wdat = r_a; n_we = 1'b1;
                            n_pc = r_pc + 16'd1;
                        end
                        ecs_pkg::OP_PUSHD, ecs_pkg::OP_PUSHH: begin
                            n_addr = r_sp - 16'd2;
                            n_wdat = (mem_q == ecs_pkg::OP_PUSHD) ? r_e : r_l;
                            n_we = 1'b1;
                            n_wa2 = r_sp - 16'd1;
                            n_wd2 = (mem_q == ecs_pkg::OP_PUSHD) ? r_d : r_h;
                            n_sp = r_sp - 16'd2; n_pc = r_pc + 16'd1;
                            n_state = S_WR;
                        end
                        default: begin
                            n_halt = 1'b1; n_status = ecs_pkg::ST_UNIMPL;
                        end
                    endcase
                end
            end
            S_RD1: begin
                n_step = 2'd0;
                n_state = S_DONE;
                case (r_op)
                    ecs_pkg::OP_DCRB: begin
                        n_b = alu_rsp.res[7:0]; n_f = {r_f[3], alu_rsp.zsp[2:0]};
                        n_pc = r_pc + 16'd1;
                    end
                    ecs_pkg::OP_DADH: begin
                        {n_h, n_l} = alu_rsp.res; n_f = {alu_rsp.cy, r_f[2:0]};
                        n_pc = r_pc + 16'd1;
                    end
                    default: begin
                        n_addr = (r_op == ecs_pkg::OP_RET) ? r_sp + 16'd1 : r_pc + 16'd2;
                        n_state = S_RD2;
                    end
                endcase
            end
            S_RD2: begin
                n_state = S_DONE;
                case (r_op)
                    ecs_pkg::OP_MVIB: begin n_b = mem_q; n_pc = r_pc + 16'd2; end
                    ecs_pkg::OP_MVIC: begin n_c = mem_q; n_pc = r_pc + 16'd2; end
                    ecs_pkg::OP_MVIH: begin n_h = mem_q; n_pc = r_pc + 16'd2; end
                    ecs_pkg::OP_LDAXD: begin n_a = mem_q; n_pc = r_pc + 16'd1; end
                    ecs_pkg::OP_MVIM: begin
                        n_addr = {r_h, r_l}; n_wdat = mem_q; n_we = 1'b1;
                        n_pc = r_pc + 16'd2;
                    end
                    ecs_pkg::OP_CPI: begin
                        n_f = {alu_rsp.cy, alu_rsp.zsp[2:0]}; n_pc = r_pc + 16'd2;
                    end
                    default: begin
                        if (r_step == 2'd0) begin
                            n_lo = mem_q; n_step = 2'd1; n_state = S_RD2;
                        end else begin
                            case (r_op)
                                ecs_pkg::OP_LXID: begin
                                    n_d = mem_q; n_e = r_lo; n_pc = r_pc + 16'd3;
                                end
                                ecs_pkg::OP_LXIH: begin
                                    n_h = mem_q; n_l = r_lo; n_pc = r_pc + 16'd3;
                                end
                                ecs_pkg::OP_LXISP: begin
                                    n_sp = {mem_q, r_lo}; n_pc = r_pc + 16'd3;
                                end
                                ecs_pkg::OP_JNZ:
                                    n_pc = r_f[0] ? r_pc + 16'd3 : {mem_q, r_lo};
                                ecs_pkg::OP_JMP: n_pc = {mem_q, r_lo};
                                ecs_pkg::OP_RET: begin
                                    n_pc = {mem_q, r_lo}; n_sp = r_sp + 16'd2;
                                end
                                default: begin
                                    n_pc = {mem_q, r_lo};
                                    n_addr = r_sp - 16'd1;
                                    n_wdat = r_pc[15:8] +
                                             (r_pc[7:0] > 8'hfc ? 8'd1 : 8'd0);
                                    n_we = 1'b1;
                                    n_wa2 = r_sp - 16'd2; n_wd2 = r_pc[7:0] + 8'd3;
                                    n_sp = r_sp - 16'd2;
                                    n_state = S_WR;
                                end
                            endcase
                        end
                    end
                endcase
            end
            S_WR: begin
                n_addr = r_wa2; n_wdat = r_wd2; n_we = 1'b1; n_state = S_DONE;
            end
            S_DONE: begin
                n_valid = 1'b1;
                if (r_valid && !i_stall) begin
                    n_valid = 1'b0; n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_pc <= 16'd0; r_sp <= 16'd0;
            r_a <= 8'd0; r_b <= 8'd0; r_c <= 8'd0; r_d <= 8'd0;
            r_e <= 8'd0; r_h <= 8'd0; r_l <= 8'd0;
            r_f <= 4'd0; r_halt <= 1'b0; r_valid <= 1'b0; r_we <= 1'b0;
        end else begin
            r_state <= n_state; r_pc <= n_pc; r_sp <= n_sp;
            r_a <= n_a; r_b <= n_b; r_c <= n_c; r_d <= n_d;
            r_e <= n_e; r_h <= n_h; r_l <= n_l;
            r_f <= n_f; r_halt <= n_halt; r_valid <= n_valid; r_we <= n_we;
        end
        r_cmd <= n_cmd; r_status <= n_status; r_op <= n_op; r_lo <= n_lo;
        r_rb <= n_rb; r_wd2 <= n_wd2; r_wa2 <= n_wa2; r_step <= n_step;
        r_addr <= n_addr; r_wdat <= n_wdat;
    end

    assign o_stall        = (r_state != S_IDLE);
    assign o_valid        = r_valid;
    assign o_status       = r_status;
    assign o_prog_counter = r_pc;
    assign o_acc          = r_a;
    assign o_reg_b        = r_b;
    assign o_reg_c        = r_c;
    assign o_reg_d        = r_d;
    assign o_reg_e        = r_e;
    assign o_reg_h        = r_h;
    assign o_reg_l        = r_l;
    assign o_stack_ptr    = r_sp;
    assign o_flag_bits    = r_f;
    assign o_read_byte    = r_rb;
endmodule

### hdl/ecs_checker.sv
// ----------------------------------------------------------------------------
// ecs_checker
// Port-level checks of the core's item handshake and results.
// ----------------------------------------------------------------------------
`include "eight_bit_cpu_subset_core_assert.svh"

module ecs_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_stall,
    input logic       o_valid,
    input logic       i_stall,
    input logic [1:0] o_status,
    input logic [3:0] o_flag_bits
);
    `ECS_ASSERT_IMP(a_one_item, i_clk, i_rst_n, o_valid, o_stall)
    `ECS_ASSERT_NXT(a_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid)
    `ECS_ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, i_valid && !o_stall, o_stall)
    `ECS_ASSERT_IMP(a_status, i_clk, i_rst_n, o_valid, o_status <= ecs_pkg::ST_HALTED)
    `ECS_ASSERT_NXT(a_result_stable, i_clk, i_rst_n, o_valid && i_stall, $stable(o_flag_bits) && $stable(o_status))
endmodule

bind eight_bit_cpu_subset_core ecs_checker u_ecs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_stall     (o_stall),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_status    (o_status),
    .o_flag_bits (o_flag_bits)
);

### dv/tb_eight_bit_cpu_subset_core.sv
// ----------------------------------------------------------------------------
// tb_eight_bit_cpu_subset_core
// Drives memory loads, reads, ignored commands and single instruction steps into
// the core and checks every result against an in-bench model of the CPU. Code is
// placed in memory on the fly so that only loaded bytes are ever fetched or read.
// ----------------------------------------------------------------------------
module tb_eight_bit_cpu_subset_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] CMD_NONE  = 2'd3;
    localparam logic [7:0] OP_UNDEF  = 8'h08;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] pc;
        logic [7:0]  a, b, c, d, e, h, l;
        logic [15:0] sp;
        logic [3:0]  flags;
        logic [7:0]  rbyte;
    } t_cpu_view;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [1:0]  i_opcode = '0;
    logic [15:0] i_mem_address = '0;
    logic [7:0]  i_mem_data = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [1:0]  o_status;
    logic [15:0] o_prog_counter;
    logic [7:0]  o_acc, o_reg_b, o_reg_c, o_reg_d, o_reg_e, o_reg_h, o_reg_l;
    logic [15:0] o_stack_ptr;
    logic [3:0]  o_flag_bits;
    logic [7:0]  o_read_byte;

    eight_bit_cpu_subset_core uut (.*);

    always #4 i_clk = ~i_clk;

    // CPU shadow state
    logic [7:0]  shadow_mem [ecs_pkg::MEM_DEPTH];
    bit          mem_loaded [ecs_pkg::MEM_DEPTH];
    logic [15:0] loaded_addrs [$];
    logic [15:0] pc_q, sp_q;
    logic [7:0]  a_q, b_q, c_q, d_q, e_q, h_q, l_q;
    logic [3:0]  flags_q;
    bit          halted_q;

    t_cpu_view   expected_views [$];
    int          mismatch_count = 0;
    int          snd_idle = 0;
    int          rcv_idle = 0;
    int          hold_cycles = 0;

    logic [7:0] impl_ops [23] = '{ecs_pkg::OP_NOP, ecs_pkg::OP_DCRB, ecs_pkg::OP_MVIB,
        ecs_pkg::OP_MVIC, ecs_pkg::OP_LXID, ecs_pkg::OP_INXD, ecs_pkg::OP_LDAXD,
        ecs_pkg::OP_LXIH, ecs_pkg::OP_INXH, ecs_pkg::OP_MVIH, ecs_pkg::OP_DADH,
        ecs_pkg::OP_LXISP, ecs_pkg::OP_MVIM, ecs_pkg::OP_MOVLA, ecs_pkg::OP_MOVMA,
        ecs_pkg::OP_MOVAH, ecs_pkg::OP_JNZ, ecs_pkg::OP_JMP, ecs_pkg::OP_RET,
        ecs_pkg::OP_CALL, ecs_pkg::OP_PUSHD, ecs_pkg::OP_PUSHH, ecs_pkg::OP_CPI};

    function automatic bit is_impl(logic [7:0] op);
        foreach (impl_ops[i]) if (impl_ops[i] == op) return 1'b1;
        return 1'b0;
    endfunction

    function automatic logic [7:0] mem_rd(logic [15:0] ad);
        return shadow_mem[ad];
    endfunction

    function automatic void mem_wr(logic [15:0] ad, logic [7:0] v);
        shadow_mem[ad] = v;
        if (!mem_loaded[ad]) begin
            mem_loaded[ad] = 1'b1;
            loaded_addrs.push_back(ad);
        end
    endfunction

    function automatic void set_zsp(logic [7:0] v);
        flags_q[0] = (v == 8'd0);
        flags_q[1] = v[7];
        flags_q[2] = ~^v;
    endfunction

    function automatic logic [1:0] exec_instr();
        logic [7:0]  op;
        logic [15:0] imm16, hl, tmp;
        logic [16:0] sum;
        int          len;
        op = mem_rd(pc_q);
        imm16 = {mem_rd(pc_q + 16'd2), mem_rd(pc_q + 16'd1)};
        hl = {h_q, l_q};
        len = 1;
        case (op)
            ecs_pkg::OP_NOP: ;
            ecs_pkg::OP_DCRB: begin
                b_q = b_q - 8'd1;
                set_zsp(b_q);
            end
            ecs_pkg::OP_MVIB: begin b_q = imm16[7:0]; len = 2; end
            ecs_pkg::OP_MVIC: begin c_q = imm16[7:0]; len = 2; end
            ecs_pkg::OP_LXID: begin {d_q, e_q} = imm16; len = 3; end
            ecs_pkg::OP_INXD: {d_q, e_q} = {d_q, e_q} + 16'd1;
            ecs_pkg::OP_LDAXD: a_q = mem_rd({d_q, e_q});
            ecs_pkg::OP_LXIH: begin {h_q, l_q} = imm16; len = 3; end
            ecs_pkg::OP_INXH: {h_q, l_q} = hl + 16'd1;
            ecs_pkg::OP_MVIH: begin h_q = imm16[7:0]; len = 2; end
            ecs_pkg::OP_DADH: begin
                sum = {1'b0, hl} + {1'b0, hl};
                flags_q[3] = sum[16];
                {h_q, l_q} = sum[15:0];
            end
            ecs_pkg::OP_LXISP: begin sp_q = imm16; len = 3; end
            ecs_pkg::OP_MVIM: begin mem_wr(hl, imm16[7:0]); len = 2; end
            ecs_pkg::OP_MOVLA: l_q = a_q;
            ecs_pkg::OP_MOVMA: mem_wr(hl, a_q);
            ecs_pkg::OP_MOVAH: a_q = h_q;
            ecs_pkg::OP_JNZ: begin
                if (!flags_q[0]) begin pc_q = imm16; len = 0; end
                else len = 3;
            end
            ecs_pkg::OP_JMP: begin pc_q = imm16; len = 0; end
            ecs_pkg::OP_RET: begin
                pc_q = {mem_rd(sp_q + 16'd1), mem_rd(sp_q)};
                sp_q = sp_q + 16'd2;
                len = 0;
            end
            ecs_pkg::OP_CALL: begin
                tmp = pc_q + 16'd3;
                mem_wr(sp_q - 16'd1, tmp[15:8]);
                mem_wr(sp_q - 16'd2, tmp[7:0]);
                sp_q = sp_q - 16'd2;
                pc_q = imm16;
                len = 0;
            end
            ecs_pkg::OP_PUSHD, ecs_pkg::OP_PUSHH: begin
                mem_wr(sp_q - 16'd2, (op == ecs_pkg::OP_PUSHD) ? e_q : l_q);
                mem_wr(sp_q - 16'd1, (op == ecs_pkg::OP_PUSHD) ? d_q : h_q);
                sp_q = sp_q - 16'd2;
            end
            ecs_pkg::OP_CPI: begin
                set_zsp(a_q - imm16[7:0]);
                flags_q[3] = (a_q < imm16[7:0]);
                len = 2;
            end
            default: begin
                halted_q = 1'b1;
                return ecs_pkg::ST_UNIMPL;
            end
        endcase
        pc_q = pc_q + 16'(len);
        return ecs_pkg::ST_OK;
    endfunction

    function automatic void cpu_model_step(logic [1:0] cmd, logic [15:0] ad, logic [7:0] dt);
        t_cpu_view v;
        v.status = ecs_pkg::ST_OK;
        v.rbyte = 8'd0;
        case (cmd)
            ecs_pkg::CMD_WRITE: mem_wr(ad, dt);
            ecs_pkg::CMD_EXEC: v.status = halted_q ? ecs_pkg::ST_HALTED : exec_instr();
            ecs_pkg::CMD_READ: v.rbyte = mem_rd(ad);
            default: ;
        endcase
        v.pc = pc_q; v.a = a_q; v.b = b_q; v.c = c_q; v.d = d_q;
        v.e = e_q; v.h = h_q; v.l = l_q; v.sp = sp_q; v.flags = flags_q;
        expected_views.push_back(v);
    endfunction

    // Called at a rising edge; returns at the edge where the item is taken.
    task automatic send_item(input logic [1:0] cmd, input logic [15:0] ad,
                             input logic [7:0] dt);
        bit stalled;
        while ($urandom_range(99) < snd_idle) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_opcode <= cmd;
        i_mem_address <= ad;
        i_mem_data <= dt;
        do begin
            @(negedge i_clk);
            stalled = o_stall;
            @(posedge i_clk);
        end while (stalled);
        cpu_model_step(cmd, ad, dt);
    endtask

    task automatic load_byte(input logic [15:0] ad, input logic [7:0] v);
        send_item(ecs_pkg::CMD_WRITE, ad, v);
    endtask

    task automatic need_byte(input logic [15:0] ad);
        if (!mem_loaded[ad]) load_byte(ad, 8'($urandom_range(255)));
    endtask

    // Places an instruction at pc (forced opcode if >= 0), loads what it reads,
    // then steps it.
    task automatic step_instr(input int forced);
        logic [15:0] p, p1, p2;
        logic [7:0]  op;
        p = pc_q;
        p1 = p + 16'd1;
        p2 = p + 16'd2;
        if (forced >= 0)
            load_byte(p, forced[7:0]);
        else if (!mem_loaded[p] || !is_impl(shadow_mem[p]) || $urandom_range(2) == 0)
            load_byte(p, impl_ops[$urandom_range(22)]);
        op = shadow_mem[p];
        case (op)
            ecs_pkg::OP_MVIB, ecs_pkg::OP_MVIC, ecs_pkg::OP_MVIH, ecs_pkg::OP_MVIM,
            ecs_pkg::OP_CPI: begin
                if ($urandom_range(1)) load_byte(p1, 8'($urandom_range(255)));
                else need_byte(p1);
            end
            ecs_pkg::OP_LXID, ecs_pkg::OP_LXIH, ecs_pkg::OP_LXISP: begin
                if ($urandom_range(1)) load_byte(p1, 8'($urandom_range(255)));
                else need_byte(p1);
                if ($urandom_range(1)) load_byte(p2, 8'($urandom_range(255)));
                else need_byte(p2);
            end
            ecs_pkg::OP_JNZ, ecs_pkg::OP_JMP, ecs_pkg::OP_CALL: begin
                if ($urandom_range(1)) load_byte(p1, 8'($urandom_range(255)));
                else need_byte(p1);
                if (!mem_loaded[p2] || $urandom_range(1))
                    load_byte(p2, ($urandom_range(3) == 0) ? 8'($urandom_range(255))
                                                           : 8'($urandom_range(1)));
            end
            ecs_pkg::OP_RET: begin
                need_byte(sp_q);
                need_byte(sp_q + 16'd1);
            end
            ecs_pkg::OP_LDAXD: need_byte({d_q, e_q});
            default: ;
        endcase
        send_item(ecs_pkg::CMD_EXEC, 16'($urandom), 8'($urandom));
    endtask

    task automatic test_memory_extremes();
        load_byte(16'hffff, 8'hff);
        load_byte(16'h0000, 8'h00);
        send_item(ecs_pkg::CMD_READ, 16'hffff, 8'h00);
        send_item(ecs_pkg::CMD_READ, 16'h0000, 8'hff);
        send_item(CMD_NONE, 16'h5a5a, 8'ha5);
    endtask

    task automatic test_directed_ops();
        step_instr(int'(ecs_pkg::OP_NOP));
        step_instr(int'(ecs_pkg::OP_DCRB));
        step_instr(int'(ecs_pkg::OP_LXIH));
        step_instr(int'(ecs_pkg::OP_DADH));
        step_instr(int'(ecs_pkg::OP_CPI));
        step_instr(int'(ecs_pkg::OP_JMP));
    endtask

    task automatic test_random_mix(input int n_items, input int s_idle, input int r_idle);
        int r;
        snd_idle = s_idle;
        rcv_idle = r_idle;
        repeat (n_items) begin
            r = $urandom_range(99);
            if (r < 55)
                step_instr(-1);
            else if (r < 68)
                load_byte(16'($urandom), 8'($urandom));
            else if (r < 78)
                load_byte(16'($urandom_range(511)), 8'($urandom));
            else if (r < 95)
                send_item(ecs_pkg::CMD_READ,
                          loaded_addrs[$urandom_range(loaded_addrs.size() - 1)],
                          8'($urandom));
            else
                send_item(CMD_NONE, 16'($urandom), 8'($urandom));
        end
    endtask

    task automatic test_backpressure();
        snd_idle = 0;
        hold_cycles <= 300;
        repeat (12) step_instr(-1);
    endtask

    // Must run last: the core stays halted until reset.
    task automatic test_halt();
        snd_idle = 10;
        rcv_idle = 10;
        step_instr(int'(OP_UNDEF));
        send_item(ecs_pkg::CMD_EXEC, 16'h0000, 8'h00);
        send_item(ecs_pkg::CMD_READ, pc_q, 8'h00);
        load_byte(16'h1234, 8'h5a);
        send_item(ecs_pkg::CMD_READ, 16'h1234, 8'h00);
        send_item(CMD_NONE, 16'hffff, 8'hff);
        send_item(ecs_pkg::CMD_EXEC, 16'hffff, 8'hff);
    endtask

    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            i_stall <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end else begin
            i_stall <= ($urandom_range(99) < rcv_idle);
        end
    end

    bit        out_take;
    t_cpu_view out_view;

    always @(negedge i_clk) begin
        out_take = i_rst_n && o_valid && !i_stall;
        out_view = '{o_status, o_prog_counter, o_acc, o_reg_b, o_reg_c, o_reg_d, o_reg_e,
                     o_reg_h, o_reg_l, o_stack_ptr, o_flag_bits, o_read_byte};
    end

    task automatic check_field(input string name, input int exp_v, input int act_v);
        if (exp_v !== act_v) begin
            mismatch_count++;
            $display("%0t %s mismatch: expected %0h actual %0h", $realtime, name, exp_v, act_v);
        end
    endtask

    always @(posedge i_clk) begin
        t_cpu_view exp_v;
        if (out_take) begin
            if (expected_views.size() == 0) begin
                mismatch_count++;
                $display("%0t unexpected result item, actual %p", $realtime, out_view);
            end else begin
                exp_v = expected_views.pop_front();
                check_field("status", exp_v.status, out_view.status);
                check_field("prog_counter", exp_v.pc, out_view.pc);
                check_field("acc", exp_v.a, out_view.a);
                check_field("reg_b", exp_v.b, out_view.b);
                check_field("reg_c", exp_v.c, out_view.c);
                check_field("reg_d", exp_v.d, out_view.d);
                check_field("reg_e", exp_v.e, out_view.e);
                check_field("reg_h", exp_v.h, out_view.h);
                check_field("reg_l", exp_v.l, out_view.l);
                check_field("stack_ptr", exp_v.sp, out_view.sp);
                check_field("flag_bits", exp_v.flags, out_view.flags);
                check_field("read_byte", exp_v.rbyte, out_view.rbyte);
            end
        end
    end

    initial begin
        #20ms;
        $display("[eight_bit_cpu_subset_core] ERROR");
        $finish;
    end

    initial begin
        int waited;
        pc_q = '0; sp_q = '0; flags_q = '0; halted_q = 1'b0;
        {a_q, b_q, c_q, d_q, e_q, h_q, l_q} = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_memory_extremes();
        test_directed_ops();
        test_random_mix(260, 16, 86);
        test_random_mix(260, 86, 16);
        test_backpressure();
        test_random_mix(260, 0, 0);
        test_halt();
        i_valid <= 1'b0;
        waited = 0;
        while (expected_views.size() != 0 && waited < 2000) begin
            @(posedge i_clk);
            waited++;
        end
        if (expected_views.size() != 0) begin
            $display("%0t %0d results never arrived", $realtime, expected_views.size());
            mismatch_count++;
        end
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("[eight_bit_cpu_subset_core] OK");
        else
            $display("[eight_bit_cpu_subset_core] ERROR");
        $finish;
    end
endmodule

### eight_bit_cpu_subset_core.f
+incdir+hdl
hdl/ecs_pkg.sv
hdl/ecs_ram.sv
hdl/ecs_alu.sv
hdl/eight_bit_cpu_subset_core.sv
hdl/ecs_checker.sv
dv/tb_eight_bit_cpu_subset_core.sv
